FILE: hdl/lcms_pkg.sv
// ----------------------------------------------------------------------------
// lcms_pkg
// Types, constants and helpers shared by the Lab colour match score block.
// ----------------------------------------------------------------------------
package lcms_pkg;

  localparam int NUM_CH          = 3;
  localparam int LEVEL_W         = 8;
  localparam int SPREAD_W        = 8;
  localparam int REG_W           = 16;
  localparam int WEIGHT_W        = 10;
  localparam int SCORE_W         = 12;
  localparam int CFG_IDX_W       = 3;
  localparam int QUOT_W          = 8;
  localparam int FACTOR_W        = QUOT_W + 1;
  localparam int PROD_W          = FACTOR_W + WEIGHT_W;
  localparam int SUM_W           = PROD_W + 2;
  localparam int GAIN_W          = 8;
  localparam int SCALED_W        = SUM_W + GAIN_W;
  localparam int SCORE_FRAC      = 16;
  localparam int STEPS_PER_STAGE = 2;
  localparam int DIV_STAGES      = QUOT_W / STEPS_PER_STAGE;

  // pipeline stage positions
  localparam int ST_FRONT   = 0;
  localparam int ST_MUL     = DIV_STAGES + 1;
  localparam int ST_SUM     = DIV_STAGES + 2;
  localparam int ST_OUT     = DIV_STAGES + 3;
  localparam int PIPE_DEPTH = DIV_STAGES + 4;

  localparam logic [FACTOR_W-1:0] FULL_FACTOR = FACTOR_W'(256);
  localparam logic [GAIN_W-1:0]   SCORE_GAIN  = GAIN_W'(255);
  localparam logic [SCORE_W-1:0]  SCORE_MAX   = SCORE_W'(3057);

  localparam logic [REG_W-1:0]    ORIGIN_SPREAD_RST = REG_W'(256);
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST        = '0;
  localparam logic [SCORE_W-1:0]  THRESHOLD_RST     = SCORE_W'(140);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_L_ORIGIN_SPREAD,
    REG_A_ORIGIN_SPREAD,
    REG_B_ORIGIN_SPREAD,
    REG_L_WEIGHT,
    REG_A_WEIGHT,
    REG_B_WEIGHT,
    REG_MATCH_THRESHOLD
  } cfg_reg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] l_level;
    logic [LEVEL_W-1:0] a_level;
    logic [LEVEL_W-1:0] b_level;
  } pixel_t;

  typedef struct packed {
    logic [SCORE_W-1:0] match_score;
    logic               is_match;
  } result_t;

  // one restoring division step: {quotient bit, new remainder}
  function automatic logic [SPREAD_W:0] div_step(input logic [SPREAD_W-1:0] rem,
                                                 input logic [SPREAD_W-1:0] dvs);
    logic [SPREAD_W:0] t;
    t = {rem, 1'b0};
    if (t >= {1'b0, dvs}) begin
      return {1'b1, SPREAD_W'(t - {1'b0, dvs})};
    end else begin
      return {1'b0, t[SPREAD_W-1:0]};
    end
  endfunction

endpackage

FILE: hdl/lcms_ifs.sv
// ----------------------------------------------------------------------------
// lcms_ifs
// Valid/ready channels of the Lab colour match score block.
// ----------------------------------------------------------------------------
interface lcms_pixel_if import lcms_pkg::*; ();
  logic   valid;
  logic   ready;
  pixel_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lcms_result_if import lcms_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lcms_cfg_if import lcms_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [REG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/lab_color_match_score.sv
// ----------------------------------------------------------------------------
// lab_color_match_score
// Scores how closely an 8-bit L, a, b pixel matches a reference colour.
// ----------------------------------------------------------------------------
// Takes one pixel word per clock when the output side does not stall and
// returns one score word per pixel, in order. After a front register, the
// per-channel factor division runs as four pipeline stages of two restoring
// steps each, followed by a multiply stage, a weighted sum stage and the
// scale-and-compare output register. Each stage holds its own valid bit, so
// bubbles close up, and a new pixel is taken while a finished score waits at
// the output as long as an earlier stage is empty. A channel with zero spread
// scores as a full match. Configuration writes are taken at any time; change
// them only while no pixel is in flight. Writes to an unused index are
// dropped.
// ----------------------------------------------------------------------------
module lab_color_match_score import lcms_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  lcms_pixel_if.sink     pix,
  lcms_result_if.source  res,
  lcms_cfg_if.sink       cfg
);

  logic [REG_W-1:0]    origin_spread [NUM_CH];
  logic [WEIGHT_W-1:0] weight [NUM_CH];
  logic [SCORE_W-1:0]  match_threshold;

  logic [LEVEL_W-1:0]  level [NUM_CH];
  logic [SPREAD_W-1:0] origin [NUM_CH];
  logic [SPREAD_W-1:0] spread [NUM_CH];

  logic [PIPE_DEPTH-1:0] vld;
  logic [PIPE_DEPTH-1:0] en;

  logic [SPREAD_W-1:0] dv_r [DIV_STAGES+1][NUM_CH];
  logic [QUOT_W-1:0]   dv_q [DIV_STAGES+1][NUM_CH];
  logic                dv_full [DIV_STAGES+1][NUM_CH];

  logic [PROD_W-1:0]   prod [NUM_CH];
  logic [SUM_W-1:0]    sum;
  logic [SCALED_W-1:0] scaled;
  logic [SCORE_W-1:0]  score;

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        origin_spread[ch] <= ORIGIN_SPREAD_RST;
        weight[ch]        <= WEIGHT_RST;
      end
      match_threshold <= THRESHOLD_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_L_ORIGIN_SPREAD: origin_spread[0] <= cfg.data;
        REG_A_ORIGIN_SPREAD: origin_spread[1] <= cfg.data;
        REG_B_ORIGIN_SPREAD: origin_spread[2] <= cfg.data;
        REG_L_WEIGHT:        weight[0] <= cfg.data[WEIGHT_W-1:0];
        REG_A_WEIGHT:        weight[1] <= cfg.data[WEIGHT_W-1:0];
        REG_B_WEIGHT:        weight[2] <= cfg.data[WEIGHT_W-1:0];
        REG_MATCH_THRESHOLD: match_threshold <= cfg.data[SCORE_W-1:0];
        default: ;
      endcase
    end
  end

  assign level[0] = pix.data.l_level;
  assign level[1] = pix.data.a_level;
  assign level[2] = pix.data.b_level;

  // per-stage valid and advance, bubbles collapse
  always_comb begin
    en[PIPE_DEPTH-1] = ~vld[PIPE_DEPTH-1] | res.ready;
    for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
      en[k] = ~vld[k] | en[k+1];
    end
  end

  assign pix.ready = en[ST_FRONT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[ST_FRONT]) begin
        vld[ST_FRONT] <= pix.valid;
      end
      for (int k = 1; k < PIPE_DEPTH; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_ch
    logic [SPREAD_W-1:0] abs_d;
    logic [SPREAD_W-1:0] clo;
    logic                full;

    assign origin[ch] = origin_spread[ch][SPREAD_W-1:0];
    assign spread[ch] = origin_spread[ch][REG_W-1:SPREAD_W];

    // clamped closeness, and whether the factor saturates at one
    always_comb begin
      abs_d = (level[ch] >= origin[ch]) ? (level[ch] - origin[ch])
                                        : (origin[ch] - level[ch]);
      clo   = (abs_d >= spread[ch]) ? '0 : (spread[ch] - abs_d);
      full  = (spread[ch] == '0) || ({clo, 1'b0} >= {1'b0, spread[ch]});
    end

    // below full, 2*closeness is under the spread and fits the remainder
    always_ff @(posedge clk) begin
      if (en[ST_FRONT]) begin
        dv_r[ST_FRONT][ch]    <= {clo[SPREAD_W-2:0], 1'b0};
        dv_q[ST_FRONT][ch]    <= '0;
        dv_full[ST_FRONT][ch] <= full;
      end
    end

    // quotient of 2*closeness/spread, fraction bits only
    for (genvar j = 1; j <= DIV_STAGES; j++) begin : g_div
      logic [SPREAD_W-1:0] r;
      logic [QUOT_W-1:0]   q;
      logic [SPREAD_W:0]   step;

      always_comb begin
        r    = dv_r[j-1][ch];
        q    = dv_q[j-1][ch];
        step = '0;
        for (int s = 0; s < STEPS_PER_STAGE; s++) begin
          step = div_step(r, spread[ch]);
          q    = {q[QUOT_W-2:0], step[SPREAD_W]};
          r    = step[SPREAD_W-1:0];
        end
      end

      always_ff @(posedge clk) begin
        if (en[j]) begin
          dv_r[j][ch]    <= r;
          dv_q[j][ch]    <= q;
          dv_full[j][ch] <= dv_full[j-1][ch];
        end
      end
    end

    logic [FACTOR_W-1:0] factor;
    assign factor = dv_full[DIV_STAGES][ch] ? FULL_FACTOR
                                            : {1'b0, dv_q[DIV_STAGES][ch]};

    always_ff @(posedge clk) begin
      if (en[ST_MUL]) begin
        prod[ch] <= PROD_W'(factor) * PROD_W'(weight[ch]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_SUM]) begin
      sum <= SUM_W'(prod[0]) + SUM_W'(prod[1]) + SUM_W'(prod[2]);
    end
  end

  assign scaled = SCALED_W'(sum) * SCALED_W'(SCORE_GAIN);
  assign score  = scaled[SCORE_FRAC +: SCORE_W];

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      res.data.match_score <= score;
      res.data.is_match    <= (score > match_threshold);
    end
  end

  assign res.valid = vld[ST_OUT];

  a_reset_empty: assert property (@(posedge clk) rst |=> !res.valid)
    else $error("result valid right after reset");

  a_taken_enters: assert property (@(posedge clk) disable iff (rst)
    (pix.valid && pix.ready) |=> vld[ST_FRONT])
    else $error("accepted pixel did not enter the front stage");

  a_match_bit: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.data.is_match == (res.data.match_score > match_threshold)))
    else $error("match bit disagrees with score and threshold");

  a_score_range: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.data.match_score <= SCORE_MAX))
    else $error("score above its largest reachable value");

endmodule

FILE: test/lcms_score_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lcms_score_checker
// Watches the pixel, result and register channels of the colour match score
// block. It keeps its own copy of the registers and predicts each score word
// from the pixel accepted. Each result word is then checked against the oldest
// prediction.
// ----------------------------------------------------------------------------
module lcms_score_checker import lcms_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  lcms_pixel_if  pix,
  lcms_result_if res,
  lcms_cfg_if    cfg,
  output int     errors,
  output int     outstanding
);

  logic [REG_W-1:0]    origin_spread [NUM_CH];
  logic [WEIGHT_W-1:0] weight [NUM_CH];
  logic [SCORE_W-1:0]  threshold;
  result_t             score_queue [$];

  // closeness of one channel in units of 1/256
  function automatic int closeness_factor(input logic [LEVEL_W-1:0] level,
                                          input logic [REG_W-1:0] org_spread);
    int origin;
    int spread;
    int delta;
    int f;
    origin = int'(org_spread[7:0]);
    spread = int'(org_spread[15:8]);
    if (spread == 0) begin
      return int'(FULL_FACTOR);
    end
    delta = int'(level) - origin;
    if (delta > spread) delta = spread;
    if (delta < -spread) delta = -spread;
    if (delta < 0) delta = -delta;
    f = (512 * (spread - delta)) / spread;
    if (f > 256) f = 256;
    return f;
  endfunction

  function automatic result_t predict_score(input pixel_t p);
    longint  weighted;
    longint  scaled;
    result_t r;
    weighted = longint'(closeness_factor(p.l_level, origin_spread[0])) * weight[0]
             + longint'(closeness_factor(p.a_level, origin_spread[1])) * weight[1]
             + longint'(closeness_factor(p.b_level, origin_spread[2])) * weight[2];
    scaled = (weighted * 255) >>> 16;
    r.match_score = scaled[SCORE_W-1:0];
    r.is_match    = (scaled > longint'(threshold));
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    result_t got;
    int      bad;
    bad = 0;
    if (rst) begin
      for (int i = 0; i < NUM_CH; i++) begin
        origin_spread[i] = ORIGIN_SPREAD_RST;
        weight[i]        = WEIGHT_RST;
      end
      threshold = THRESHOLD_RST;
      score_queue.delete();
      errors      <= 0;
      outstanding <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_L_ORIGIN_SPREAD: origin_spread[0] = cfg.data;
          REG_A_ORIGIN_SPREAD: origin_spread[1] = cfg.data;
          REG_B_ORIGIN_SPREAD: origin_spread[2] = cfg.data;
          REG_L_WEIGHT:        weight[0] = cfg.data[WEIGHT_W-1:0];
          REG_A_WEIGHT:        weight[1] = cfg.data[WEIGHT_W-1:0];
          REG_B_WEIGHT:        weight[2] = cfg.data[WEIGHT_W-1:0];
          REG_MATCH_THRESHOLD: threshold = cfg.data[SCORE_W-1:0];
          default: ;
        endcase
      end
      if (pix.valid && pix.ready) begin
        score_queue = {score_queue, predict_score(pix.data)};
      end
      if (res.valid && res.ready) begin
        got = res.data;
        if (score_queue.size() == 0) begin
          $display("%0t: unexpected result word, score %0d match %0b",
                   $time, got.match_score, got.is_match);
          bad++;
        end else begin
          want = score_queue.pop_front();
          if (got.match_score !== want.match_score) begin
            $display("%0t: match_score mismatch, expected %0d, actual %0d",
                     $time, want.match_score, got.match_score);
            bad++;
          end
          if (got.is_match !== want.is_match) begin
            $display("%0t: is_match mismatch, expected %0b, actual %0b",
                     $time, want.is_match, got.is_match);
            bad++;
          end
        end
      end
      errors      <= errors + bad;
      outstanding <= score_queue.size();
    end
  end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the Lab colour match score block. A short directed run covers
// reset values, register extremes, zero spread, clamping and the threshold
// edge; random phases follow with new register settings each time and, in
// some phases, random gaps on the pixel side and stalls on the result side.
// ----------------------------------------------------------------------------
module testbench;
  import lcms_pkg::*;

  localparam int                   CYCLE_LIMIT    = 400000;
  localparam int                   RANDOM_PHASES  = 12;
  localparam int                   PHASE_ITEMS    = 50;
  localparam logic [CFG_IDX_W-1:0] UNUSED_REG_IDX = CFG_IDX_W'(7);

  logic clk;
  logic rst;
  logic tx_gaps;
  logic rx_stalls;
  int   stall_left = 0;
  int   cycles = 0;
  int   errors;
  int   outstanding;

  lcms_pixel_if  pix_ch ();
  lcms_result_if res_ch ();
  lcms_cfg_if    cfg_ch ();

  lab_color_match_score dut (
    .clk (clk),
    .rst (rst),
    .pix (pix_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  lcms_score_checker score_chk (
    .clk         (clk),
    .rst         (rst),
    .pix         (pix_ch),
    .res         (res_ch),
    .cfg         (cfg_ch),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [LEVEL_W-1:0] near_level(input int origin, input int spread);
    int v;
    v = origin + $urandom_range(0, 2 * spread + 4) - (spread + 2);
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return LEVEL_W'(v);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (!rx_stalls) begin
      res_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      res_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      res_ch.ready <= 1'b0;
      stall_left   <= pick_gap();
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  task automatic send_pixel(input logic [LEVEL_W-1:0] l, input logic [LEVEL_W-1:0] a,
                            input logic [LEVEL_W-1:0] b);
    int gap;
    gap = tx_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_ch.valid        <= 1'b1;
    pix_ch.data.l_level <= l;
    pix_ch.data.a_level <= a;
    pix_ch.data.b_level <= b;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
  endtask

  // stop sending and wait for every score word in flight
  task automatic drain();
    pix_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // leaves valid high so back-to-back writes need no lowering
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic program_all(input logic [REG_W-1:0] l_os, input logic [REG_W-1:0] a_os,
                             input logic [REG_W-1:0] b_os, input logic [REG_W-1:0] l_w,
                             input logic [REG_W-1:0] a_w, input logic [REG_W-1:0] b_w,
                             input logic [REG_W-1:0] thr);
    write_reg(REG_L_ORIGIN_SPREAD, l_os);
    write_reg(REG_A_ORIGIN_SPREAD, a_os);
    write_reg(REG_B_ORIGIN_SPREAD, b_os);
    write_reg(REG_L_WEIGHT, l_w);
    write_reg(REG_A_WEIGHT, a_w);
    write_reg(REG_B_WEIGHT, b_w);
    write_reg(REG_MATCH_THRESHOLD, thr);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    int                  origin [NUM_CH];
    int                  spread [NUM_CH];
    int                  r;
    int                  thr;
    logic [LEVEL_W-1:0]  lvl [NUM_CH];

    rst          <= 1'b1;
    tx_gaps      <= 1'b0;
    rx_stalls    <= 1'b0;
    pix_ch.valid <= 1'b0;
    pix_ch.data  <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values: zero weights give a zero score
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd1, 8'd1, 8'd1);
    drain();

    // spread 10 around mid scale, write to an unused index first
    write_reg(UNUSED_REG_IDX, 16'hFFFF);
    program_all({8'd10, 8'd128}, {8'd10, 8'd128}, {8'd10, 8'd128},
                16'd256, 16'd256, 16'd256, 16'd700);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd133, 8'd123, 8'd133);
    send_pixel(8'd134, 8'd122, 8'd134);
    send_pixel(8'd138, 8'd118, 8'd138);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd131, 8'd130, 8'd136);
    drain();

    // zero spread on L and a, widest spread on b, wide values masked
    program_all({8'd0, 8'd255}, {8'd0, 8'd0}, {8'd255, 8'd0},
                16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd7, 8'd128);
    send_pixel(8'd17, 8'd200, 8'd127);
    drain();

    // threshold edges around a full L score of 1019
    program_all({8'd1, 8'd255}, 16'd256, 16'd256, 16'd1023, 16'd0, 16'd0, 16'd0);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd254, 8'd0, 8'd0);
    drain();
    program_all({8'd1, 8'd255}, 16'd256, 16'd256, 16'd1023, 16'd0, 16'd0, 16'd1019);
    send_pixel(8'd255, 8'd0, 8'd0);
    drain();
    program_all({8'd1, 8'd255}, 16'd256, 16'd256, 16'd1023, 16'd0, 16'd0, 16'd1018);
    send_pixel(8'd255, 8'd0, 8'd0);
    drain();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      for (int c = 0; c < NUM_CH; c++) begin
        origin[c] = $urandom_range(0, 255);
        r = $urandom_range(0, 9);
        if (r == 0) spread[c] = 0;
        else if (r == 1) spread[c] = 255;
        else if (r < 6) spread[c] = $urandom_range(1, 16);
        else spread[c] = $urandom_range(1, 255);
      end
      r = $urandom_range(0, 9);
      if (r == 0) thr = 0;
      else if (r == 1) thr = 4095;
      else thr = $urandom_range(0, 3100);
      program_all({8'(spread[0]), 8'(origin[0])}, {8'(spread[1]), 8'(origin[1])},
                  {8'(spread[2]), 8'(origin[2])}, 16'($urandom()), 16'($urandom()),
                  16'($urandom()), {4'($urandom()), 12'(thr)});
      // every mix of gaps and stalls, including none at all
      tx_gaps   <= ph[0];
      rx_stalls <= ph[1];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        for (int c = 0; c < NUM_CH; c++) begin
          if ($urandom_range(0, 3) != 0) lvl[c] = near_level(origin[c], spread[c]);
          else lvl[c] = 8'($urandom());
        end
        send_pixel(lvl[0], lvl[1], lvl[2]);
      end
      drain();
    end

    repeat (4 * PIPE_DEPTH) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/lcms_pkg.sv
hdl/lcms_ifs.sv
hdl/lab_color_match_score.sv
test/lcms_score_checker.sv
test/testbench.sv
